// ----- src/sha1md_pkg.sv -----
// Shared types, constants and codes of the SHA-1 message digest block.
package sha1md_pkg;

    // Number of compression rounds per 64-byte block.
    localparam int unsigned ROUNDS = 80;
    localparam int unsigned ROUND_W = 7;

    // Default depth of the request queue between front and engine.
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    // Byte slot at which the 64-bit length field begins.
    localparam logic [5:0] LENGTH_SLOT = 6'd56;

    // Last byte slot of a block.
    localparam logic [5:0] LAST_SLOT = 6'd63;

    // Padding marker byte.
    localparam logic [7:0] PAD_MARK = 8'h80;

    // Initial chain values.
    localparam logic [31:0] IV [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // Round constants, one for each group of twenty rounds.
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    // Kind of request handed from the front to the engine.
    typedef enum logic [1:0] {
        CMD_BYTE,
        CMD_BYTE_LAST,
        CMD_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    // Engine sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_ZERO,
        ST_LEN,
        ST_COMPRESS,
        ST_ADD,
        ST_OUT
    } eng_state_t;

    // Engine status seen by the top level.
    typedef struct packed {
        logic               idle;
        logic               compressing;
        logic [ROUND_W-1:0] round;
    } eng_status_t;

endpackage

// ----- src/sha1md_front.sv -----
// Front end: accepts input items, classifies them and queues requests for the engine.
module sha1md_front #(
    parameter int unsigned QUEUE_DEPTH = sha1md_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_data_byte,
    input  logic              s_byte_present,
    input  logic              s_last_item,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output sha1md_pkg::cmd_t  cmd
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    sha1md_pkg::cmd_t  queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    sha1md_pkg::cmd_t  cmd_new;
    logic              push;
    logic              pop;

    // Classify the item; an empty item that does not end the message is dropped.
    always_comb begin
        cmd_new.data = s_data_byte;
        if (s_byte_present && s_last_item) begin
            cmd_new.kind = sha1md_pkg::CMD_BYTE_LAST;
        end else if (s_byte_present) begin
            cmd_new.kind = sha1md_pkg::CMD_BYTE;
        end else begin
            cmd_new.kind = sha1md_pkg::CMD_END;
        end
    end

    assign s_ready   = (count_reg != CNT_FULL);
    assign push      = s_valid && s_ready && (s_byte_present || s_last_item);
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = queue_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= cmd_new;
        end
    end

endmodule

// ----- src/sha1md_engine.sv -----
// Back end: byte packing, padding, 80-round compression and digest output register.
module sha1md_engine (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  sha1md_pkg::cmd_t         cmd,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [31:0]              m_digest_w0,
    output logic [31:0]              m_digest_w1,
    output logic [31:0]              m_digest_w2,
    output logic [31:0]              m_digest_w3,
    output logic [31:0]              m_digest_w4,
    output sha1md_pkg::eng_status_t  status
);

    localparam logic [sha1md_pkg::ROUND_W-1:0] ROUND_END =
        sha1md_pkg::ROUND_W'(sha1md_pkg::ROUNDS - 1);

    sha1md_pkg::eng_state_t state_reg, state_next;
    sha1md_pkg::eng_state_t ret_reg, ret_next;
    logic [5:0]                      pos_reg, pos_next;
    logic [63:0]                     bits_reg, bits_next;
    logic [sha1md_pkg::ROUND_W-1:0]  round_reg, round_next;
    logic [31:0]                     chain_reg [5];
    logic [31:0]                     chain_next [5];
    logic [31:0]                     work_reg [5];
    logic [31:0]                     work_next [5];
    logic [31:0]                     sched_reg [16];
    logic [31:0]                     sched_next [16];
    logic [31:0]                     out_reg [5];
    logic [31:0]                     out_next [5];
    logic                            m_valid_reg, m_valid_next;

    logic        put_en;
    logic [7:0]  put_byte;
    logic        block_full;
    logic [63:0] len_shift;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_val;
    logic [31:0] w_new;

    function automatic logic [31:0] rotl5(input logic [31:0] v);
        return {v[26:0], v[31:27]};
    endfunction

    function automatic logic [31:0] rotl30(input logic [31:0] v);
        return {v[1:0], v[31:2]};
    endfunction

    function automatic logic [31:0] rotl1(input logic [31:0] v);
        return {v[30:0], v[31]};
    endfunction

    assign cmd_ready  = (state_reg == sha1md_pkg::ST_IDLE);
    assign block_full = (pos_reg == sha1md_pkg::LAST_SLOT);

    // Length byte for the current slot, most significant byte first.
    assign len_shift = bits_reg >> {3'(~pos_reg[2:0]), 3'b000};

    // Round function and constant for the current round group.
    always_comb begin
        if (round_reg < 7'd20) begin
            f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            k_val = sha1md_pkg::K0;
        end else if (round_reg < 7'd40) begin
            f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k_val = sha1md_pkg::K1;
        end else if (round_reg < 7'd60) begin
            f_val = (work_reg[1] & work_reg[2]) | (work_reg[1] & work_reg[3])
                  | (work_reg[2] & work_reg[3]);
            k_val = sha1md_pkg::K2;
        end else begin
            f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k_val = sha1md_pkg::K3;
        end
        t_val = rotl5(work_reg[0]) + f_val + work_reg[4] + k_val + sched_reg[0];
        w_new = rotl1(sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0]);
    end

    // Sequencer: next state and datapath control.
    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        pos_next     = pos_reg;
        bits_next    = bits_reg;
        round_next   = round_reg;
        m_valid_next = m_valid_reg;
        put_en       = 1'b0;
        put_byte     = cmd.data;
        chain_next   = chain_reg;
        work_next    = work_reg;
        sched_next   = sched_reg;
        out_next     = out_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            sha1md_pkg::ST_IDLE: begin
                if (cmd_valid) begin
                    unique case (cmd.kind)
                        sha1md_pkg::CMD_BYTE: begin
                            put_en     = 1'b1;
                            bits_next  = bits_reg + 64'd8;
                            ret_next   = sha1md_pkg::ST_IDLE;
                            state_next = block_full ? sha1md_pkg::ST_COMPRESS
                                                    : sha1md_pkg::ST_IDLE;
                        end
                        sha1md_pkg::CMD_BYTE_LAST: begin
                            put_en     = 1'b1;
                            bits_next  = bits_reg + 64'd8;
                            ret_next   = sha1md_pkg::ST_MARK;
                            state_next = block_full ? sha1md_pkg::ST_COMPRESS
                                                    : sha1md_pkg::ST_MARK;
                        end
                        sha1md_pkg::CMD_END: begin
                            state_next = sha1md_pkg::ST_MARK;
                        end
                        default: begin
                            state_next = sha1md_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            sha1md_pkg::ST_MARK: begin
                put_en     = 1'b1;
                put_byte   = sha1md_pkg::PAD_MARK;
                ret_next   = sha1md_pkg::ST_ZERO;
                state_next = block_full ? sha1md_pkg::ST_COMPRESS : sha1md_pkg::ST_ZERO;
            end
            sha1md_pkg::ST_ZERO: begin
                if (pos_reg == sha1md_pkg::LENGTH_SLOT) begin
                    state_next = sha1md_pkg::ST_LEN;
                end else begin
                    put_en     = 1'b1;
                    put_byte   = 8'h00;
                    ret_next   = sha1md_pkg::ST_ZERO;
                    state_next = block_full ? sha1md_pkg::ST_COMPRESS
                                            : sha1md_pkg::ST_ZERO;
                end
            end
            sha1md_pkg::ST_LEN: begin
                put_en     = 1'b1;
                put_byte   = len_shift[7:0];
                ret_next   = sha1md_pkg::ST_OUT;
                state_next = block_full ? sha1md_pkg::ST_COMPRESS : sha1md_pkg::ST_LEN;
            end
            sha1md_pkg::ST_COMPRESS: begin
                work_next[0] = t_val;
                work_next[1] = work_reg[0];
                work_next[2] = rotl30(work_reg[1]);
                work_next[3] = work_reg[2];
                work_next[4] = work_reg[3];
                for (int i = 0; i < 15; i++) begin
                    sched_next[i] = sched_reg[i+1];
                end
                sched_next[15] = w_new;
                if (round_reg == ROUND_END) begin
                    round_next = '0;
                    state_next = sha1md_pkg::ST_ADD;
                end else begin
                    round_next = round_reg + 1'b1;
                end
            end
            sha1md_pkg::ST_ADD: begin
                for (int i = 0; i < 5; i++) begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
                state_next = ret_reg;
            end
            sha1md_pkg::ST_OUT: begin
                // Wait until the output register is free, then re-arm.
                if (!m_valid_reg || m_ready) begin
                    out_next     = chain_reg;
                    m_valid_next = 1'b1;
                    chain_next   = sha1md_pkg::IV;
                    bits_next    = '0;
                    state_next   = sha1md_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sha1md_pkg::ST_IDLE;
            end
        endcase

        // Shift one byte into the block line; a full block starts compression.
        if (put_en) begin
            for (int i = 0; i < 15; i++) begin
                sched_next[i] = {sched_reg[i][23:0], sched_reg[i+1][31:24]};
            end
            sched_next[15] = {sched_reg[15][23:0], put_byte};
            pos_next       = pos_reg + 1'b1;
            if (block_full) begin
                work_next  = chain_reg;
                round_next = '0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sha1md_pkg::ST_IDLE;
            ret_reg     <= sha1md_pkg::ST_IDLE;
            pos_reg     <= '0;
            bits_reg    <= '0;
            round_reg   <= '0;
            m_valid_reg <= 1'b0;
            chain_reg   <= sha1md_pkg::IV;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            pos_reg     <= pos_next;
            bits_reg    <= bits_next;
            round_reg   <= round_next;
            m_valid_reg <= m_valid_next;
            chain_reg   <= chain_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge aclk) begin
        work_reg  <= work_next;
        sched_reg <= sched_next;
        out_reg   <= out_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_digest_w0 = out_reg[0];
    assign m_digest_w1 = out_reg[1];
    assign m_digest_w2 = out_reg[2];
    assign m_digest_w3 = out_reg[3];
    assign m_digest_w4 = out_reg[4];

    assign status.idle        = (state_reg == sha1md_pkg::ST_IDLE);
    assign status.compressing = (state_reg == sha1md_pkg::ST_COMPRESS);
    assign status.round       = round_reg;

endmodule

// ----- src/sha1_message_digest_top.sv -----
// SHA-1 digest of a byte stream, one byte per request, with the digest given on the last request.
// Throughput: one byte a cycle into the engine while it is idle; a full block stalls intake for the
// 80 rounds of the single round unit and the chain add.
// After the engine takes an end request it writes the mark, the zero fill and the eight length
// bytes, runs one or two compressions and then loads the output register.
// Reset (aresetn, synchronous, active low) empties the queue and loads the initial chain at once.
module sha1_message_digest_top #(
    parameter int unsigned QUEUE_DEPTH = sha1md_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_present,
    input  logic        s_last_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_w0,
    output logic [31:0] m_digest_w1,
    output logic [31:0] m_digest_w2,
    output logic [31:0] m_digest_w3,
    output logic [31:0] m_digest_w4
);

    logic                     cmd_valid;
    logic                     cmd_ready;
    sha1md_pkg::cmd_t         cmd;
    sha1md_pkg::eng_status_t  status;

    // Front end with the request queue.
    sha1md_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_byte_present (s_byte_present),
        .s_last_item    (s_last_item),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd)
    );

    // Compression engine and output register.
    sha1md_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_digest_w0 (m_digest_w0),
        .m_digest_w1 (m_digest_w1),
        .m_digest_w2 (m_digest_w2),
        .m_digest_w3 (m_digest_w3),
        .m_digest_w4 (m_digest_w4),
        .status      (status)
    );

    // A full queue always has a request waiting for the engine.
    assert property (@(posedge aclk) disable iff (!aresetn) !s_ready |-> cmd_valid)
        else $error("queue full but no request offered to the engine");

    // Rounds run back to back inside one compression.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (status.compressing && status.round != '0) |-> $past(status.compressing))
        else $error("compression round counter advanced outside a compression");

    // The round counter rests at zero outside a compression.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !status.compressing |-> (status.round == '0))
        else $error("round counter not at zero between compressions");

    // A digest request is raised only from the output step, never while taking requests.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(cmd_ready))
        else $error("digest raised while the engine was taking requests");

endmodule
